// ===== sv/multi_channel_pwm_fader_macros.svh =====
// Assertion macros shared by the fader RTL.
`ifndef MULTI_CHANNEL_PWM_FADER_MACROS_SVH
`define MULTI_CHANNEL_PWM_FADER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication check.
`define MCPF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcpf check failed");

// Next-cycle implication check.
`define MCPF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcpf check failed");

`else

`define MCPF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MCPF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/mcpf_pkg.sv =====
// Shared types and constants of the PWM fader.
package mcpf_pkg;

   // fixed channel count: one named field per channel
   localparam int CHANNELS = 5;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // one tick is 16 ms
   localparam int TICK_SHIFT = 4;

   localparam int DEF_DUTY_BITS     = 8;
   localparam int DEF_DURATION_BITS = 16;

   // action codes
   localparam logic ACT_SET  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_OUT
   } state_type;

   // what an accepted beat does
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_STEP,
      KIND_FINAL
   } kind_type;

   typedef struct packed {
      logic            accept;
      logic            load_mul;
      logic            div_step;
      logic            write_ch;
      logic            load_out;
      logic [CH_W-1:0] ch;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
   } stat_type;

endpackage

// ===== sv/mcpf_if.sv =====
// Valid/ready channel interfaces for the fader request and response.
interface mcpf_req_if import mcpf_pkg::*; #(
   parameter int DUTY_BITS     = DEF_DUTY_BITS,
   parameter int DURATION_BITS = DEF_DURATION_BITS
);
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [DUTY_BITS-1:0]     target_a;
   logic [DUTY_BITS-1:0]     target_b;
   logic [DUTY_BITS-1:0]     target_c;
   logic [DUTY_BITS-1:0]     target_d;
   logic [DUTY_BITS-1:0]     target_e;
   logic [DURATION_BITS-1:0] duration_ms;

   modport source (
      output valid, action, target_a, target_b, target_c, target_d, target_e, duration_ms,
      input  ready
   );
   modport sink (
      input  valid, action, target_a, target_b, target_c, target_d, target_e, duration_ms,
      output ready
   );
endinterface

interface mcpf_rsp_if import mcpf_pkg::*; #(
   parameter int DUTY_BITS = DEF_DUTY_BITS
);
   logic                 valid;
   logic                 ready;
   logic [DUTY_BITS-1:0] duty_a;
   logic [DUTY_BITS-1:0] duty_b;
   logic [DUTY_BITS-1:0] duty_c;
   logic [DUTY_BITS-1:0] duty_d;
   logic [DUTY_BITS-1:0] duty_e;
   logic                 fade_done;

   modport source (
      output valid, duty_a, duty_b, duty_c, duty_d, duty_e, fade_done,
      input  ready
   );
   modport sink (
      input  valid, duty_a, duty_b, duty_c, duty_d, duty_e, fade_done,
      output ready
   );
endinterface

// ===== sv/mcpf_ctrl.sv =====
// Sequencer of the fader: walks channels through multiply, divide and write.
`include "multi_channel_pwm_fader_macros.svh"

module mcpf_ctrl import mcpf_pkg::*; #(
   parameter int DUTY_BITS = DEF_DUTY_BITS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam int              BIT_W    = (DUTY_BITS > 1) ? $clog2(DUTY_BITS) : 1;
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DUTY_BITS - 1);
   localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(CHANNELS - 1);

   state_type        state_ff, state_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (stat.kind)
                  KIND_STEP:  state_in = ST_MUL;
                  KIND_FINAL: state_in = ST_OUT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:   state_in = ST_DIV;
         ST_DIV: begin
            if (bit_ff == BIT_LAST) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = (ch_ff == CH_LAST) ? ST_OUT : ST_MUL;
         ST_OUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // channel and quotient-bit counters
   always_comb begin
      ch_in  = ch_ff;
      bit_in = bit_ff;
      unique case (state_ff)
         ST_IDLE:  ch_in  = '0;
         ST_MUL:   bit_in = '0;
         ST_DIV:   bit_in = bit_ff + 1'b1;
         ST_WRITE: ch_in  = ch_ff + 1'b1;
         default:  ;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.load_mul = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.write_ch = (state_ff == ST_WRITE);
      cmd.load_out = (state_ff == ST_OUT) && stat.out_free;
      cmd.ch       = ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         bit_ff   <= bit_in;
      end
   end

   `MCPF_ASSERT_NXT(a_div_ends, clock, reset, state_ff == ST_DIV && bit_ff == BIT_LAST, state_ff == ST_WRITE)
   `MCPF_ASSERT_NXT(a_final_to_out, clock, reset, accept && stat.kind == KIND_FINAL, state_ff == ST_OUT)
   `MCPF_ASSERT_NXT(a_last_ch_out, clock, reset, state_ff == ST_WRITE && ch_ff == CH_LAST, state_ff == ST_OUT)

endmodule

// ===== sv/mcpf_datapath.sv =====
// Fader datapath: fade state, shared multiplier and restoring divider, output register.
`include "multi_channel_pwm_fader_macros.svh"

module mcpf_datapath import mcpf_pkg::*; #(
   parameter int DUTY_BITS     = DEF_DUTY_BITS,
   parameter int DURATION_BITS = DEF_DURATION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cmd_type                             cmd,
   output stat_type                            stat,
   input  logic                                req_action,
   input  logic [CHANNELS-1:0][DUTY_BITS-1:0]  req_target,
   input  logic [DURATION_BITS-1:0]            req_duration,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [CHANNELS-1:0][DUTY_BITS-1:0]  rsp_duty,
   output logic                                rsp_done
);

   localparam int STEP_W = DURATION_BITS - TICK_SHIFT;
   localparam int PROD_W = DUTY_BITS + DURATION_BITS;

   typedef logic [CHANNELS-1:0][DUTY_BITS-1:0] duty_vec_type;

   // fade state
   duty_vec_type             cur_ff, cur_in;
   duty_vec_type             start_ff, start_in;
   duty_vec_type             target_ff, target_in;
   logic [DURATION_BITS-1:0] dur_ff, dur_in;
   logic [STEP_W-1:0]        step_idx_ff, step_idx_in;
   logic [STEP_W-1:0]        step_tot_ff, step_tot_in;
   logic                     fading_ff, fading_in;
   logic                     done_pend_ff, done_pend_in;

   // divider
   logic [DURATION_BITS-1:0] rem_ff, rem_in;
   logic [DUTY_BITS-1:0]     lo_ff, lo_in;
   logic                     neg_ff, neg_in;

   // output register
   duty_vec_type             out_duty_ff, out_duty_in;
   logic                     out_done_ff, out_done_in;
   logic                     out_valid_ff, out_valid_in;

   kind_type                 kind;
   logic [STEP_W-1:0]        in_tot;
   logic [DUTY_BITS-1:0]     sel_start, sel_tgt, mag;
   logic                     sel_neg;
   logic [PROD_W-1:0]        prod;
   logic [DURATION_BITS:0]   shifted, diff;
   logic                     ge;
   logic [DUTY_BITS:0]       lo_shift;
   logic [DUTY_BITS-1:0]     step_res;

   assign in_tot = req_duration[DURATION_BITS-1:TICK_SHIFT];

   // classify the beat on the request port
   always_comb begin
      if (req_action == ACT_SET) begin
         kind = (in_tot == '0) ? KIND_FINAL : KIND_STEP;
      end else if (!fading_ff) begin
         kind = KIND_NONE;
      end else if (step_idx_ff < step_tot_ff) begin
         kind = KIND_STEP;
      end else begin
         kind = KIND_FINAL;
      end
   end

   assign stat.kind     = kind;
   assign stat.out_free = !out_valid_ff || rsp_ready;

   // |target - start| * 16 * i for the selected channel
   assign sel_start = start_ff[cmd.ch];
   assign sel_tgt   = target_ff[cmd.ch];
   assign sel_neg   = sel_tgt < sel_start;
   assign mag       = sel_neg ? (sel_start - sel_tgt) : (sel_tgt - sel_start);
   assign prod      = PROD_W'(mag) * PROD_W'({step_idx_ff, {TICK_SHIFT{1'b0}}});

   // one restoring divide step; quotient fits DUTY_BITS since 16*i <= duration
   assign shifted  = {rem_ff, lo_ff[DUTY_BITS-1]};
   assign diff     = shifted - {1'b0, dur_ff};
   assign ge       = shifted >= {1'b0, dur_ff};
   assign lo_shift = {lo_ff, ge};

   // step value: quotient applied toward the target
   assign step_res = neg_ff ? (sel_start - lo_ff) : (sel_start + lo_ff);

   // fade state update
   always_comb begin
      cur_in       = cur_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      dur_in       = dur_ff;
      step_idx_in  = step_idx_ff;
      step_tot_in  = step_tot_ff;
      fading_in    = fading_ff;
      done_pend_in = done_pend_ff;
      if (cmd.accept) begin
         done_pend_in = (kind == KIND_FINAL);
         if (req_action == ACT_SET) begin
            start_in    = cur_ff;
            target_in   = req_target;
            dur_in      = req_duration;
            step_tot_in = in_tot;
            if (in_tot == '0) begin
               step_idx_in = '0;
               cur_in      = req_target;
               fading_in   = 1'b0;
            end else begin
               step_idx_in = STEP_W'(1);
               fading_in   = 1'b1;
            end
         end else if (kind == KIND_STEP) begin
            step_idx_in = step_idx_ff + 1'b1;
         end else if (kind == KIND_FINAL) begin
            cur_in    = target_ff;
            fading_in = 1'b0;
         end
      end
      if (cmd.write_ch) begin
         cur_in[cmd.ch] = step_res;
      end
   end

   // divider registers
   always_comb begin
      rem_in = rem_ff;
      lo_in  = lo_ff;
      neg_in = neg_ff;
      if (cmd.load_mul) begin
         rem_in = prod[PROD_W-1:DUTY_BITS];
         lo_in  = prod[DUTY_BITS-1:0];
         neg_in = sel_neg;
      end else if (cmd.div_step) begin
         rem_in = ge ? diff[DURATION_BITS-1:0] : shifted[DURATION_BITS-1:0];
         lo_in  = lo_shift[DUTY_BITS-1:0];
      end
   end

   // response beat register
   always_comb begin
      out_duty_in  = out_duty_ff;
      out_done_in  = out_done_ff;
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_duty_in  = cur_ff;
         out_done_in  = done_pend_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         step_idx_ff  <= '0;
         step_tot_ff  <= '0;
         fading_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         step_idx_ff  <= step_idx_in;
         step_tot_ff  <= step_tot_in;
         fading_ff    <= fading_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      target_ff    <= target_in;
      dur_ff       <= dur_in;
      done_pend_ff <= done_pend_in;
      rem_ff       <= rem_in;
      lo_ff        <= lo_in;
      neg_ff       <= neg_in;
      out_duty_ff  <= out_duty_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_duty  = out_duty_ff;
   assign rsp_done  = out_done_ff;

   `MCPF_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.load_out, !out_valid_ff || rsp_ready)
   `MCPF_ASSERT_NXT(a_final_stops, clock, reset, cmd.accept && kind == KIND_FINAL, !fading_ff)
   `MCPF_ASSERT_NXT(a_step_runs, clock, reset, cmd.accept && kind == KIND_STEP, fading_ff && step_idx_ff != '0)

endmodule

// ===== sv/multi_channel_pwm_fader.sv =====
// Five-channel linear PWM duty fader, top level.
//
// Request channel (req_if): one beat is either a set command (targets for
// five duty channels plus a fade time in ms) or a 16 ms tick. Response
// channel (rsp_if): five duties to drive and fade_done on the last write.
// A set with a fade under 16 ms answers with the targets and fade_done.
// Longer fades answer with step 1 at once, then one step per tick, and the
// tick after the last step answers with the exact targets. Idle ticks give
// no response beat. A set during a fade restarts from the duties driven.
// Path: a step beat passes through one shared multiplier and a
// one-bit-per-cycle restoring divider visited per channel, then the
// response register; a final or immediate beat goes from acceptance to
// the output state and then into the response register.
// The request side is busy while a step or final beat is in the sequencer, not for an idle tick.
// Requests are taken one at a time; the next is accepted once the current
// beat sits in the response register, even if the receiver stalls it.
// A stalled response holds the sequencer in its output state until taken.
// Reset (synchronous, active high) zeroes the duties and stops any fade.
module multi_channel_pwm_fader import mcpf_pkg::*; #(
   parameter int DUTY_BITS     = DEF_DUTY_BITS,
   parameter int DURATION_BITS = DEF_DURATION_BITS
) (
   input logic         clock,
   input logic         reset,
   mcpf_req_if.sink    req_if,
   mcpf_rsp_if.source  rsp_if
);

   cmd_type                            cmd;
   stat_type                           stat;
   logic [CHANNELS-1:0][DUTY_BITS-1:0] req_target;
   logic [CHANNELS-1:0][DUTY_BITS-1:0] rsp_duty;

   // channel a is index 0
   assign req_target = {req_if.target_e, req_if.target_d, req_if.target_c,
                        req_if.target_b, req_if.target_a};

   mcpf_ctrl #(
      .DUTY_BITS (DUTY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mcpf_datapath #(
      .DUTY_BITS     (DUTY_BITS),
      .DURATION_BITS (DURATION_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_action   (req_if.action),
      .req_target   (req_target),
      .req_duration (req_if.duration_ms),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_duty     (rsp_duty),
      .rsp_done     (rsp_if.fade_done)
   );

   assign rsp_if.duty_a = rsp_duty[0];
   assign rsp_if.duty_b = rsp_duty[1];
   assign rsp_if.duty_c = rsp_duty[2];
   assign rsp_if.duty_d = rsp_duty[3];
   assign rsp_if.duty_e = rsp_duty[4];

endmodule

// ===== bench/fade_duty_checker.sv =====
// Checker for the PWM fader: predicts every duty write and compares the response beats.
`timescale 1ns / 100ps

module fade_duty_checker import mcpf_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   mcpf_req_if   req,
   mcpf_rsp_if   rsp,
   output int    errors,
   output int    pending
);

   localparam int DW = DEF_DUTY_BITS;
   localparam int SW = DEF_DURATION_BITS;

   typedef logic [CHANNELS-1:0][DW-1:0] duty_set_type;

   typedef struct packed {
      duty_set_type duty;
      logic         done;
   } duty_write_type;

   // fade state, mirrored from the block
   duty_set_type  driven_duty;
   duty_set_type  ramp_from;
   duty_set_type  ramp_to;
   logic [SW-1:0] ramp_ms;
   logic [11:0]   ramp_step;
   logic [11:0]   ramp_steps;
   logic          ramping;

   duty_write_type duty_writes_due[$];
   int             mismatches = 0;

   assign errors = mismatches;

   // start + trunc((target - start) * 16 * step / duration), toward zero
   function automatic logic [DW-1:0] ramp_point(input logic [DW-1:0] from,
                                                input logic [DW-1:0] to,
                                                input logic [11:0] step,
                                                input logic [SW-1:0] ms);
      longint unsigned span;
      longint unsigned q;
      if (to >= from) begin
         span = longint'(to) - longint'(from);
         q = (span * 16 * longint'(step)) / longint'(ms);
         return DW'(longint'(from) + q);
      end
      span = longint'(from) - longint'(to);
      q = (span * 16 * longint'(step)) / longint'(ms);
      return DW'(longint'(from) - q);
   endfunction

   // current step of the ramp onto the outputs
   function automatic duty_write_type drive_ramp_step();
      duty_write_type w;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         driven_duty[ch] = ramp_point(ramp_from[ch], ramp_to[ch], ramp_step, ramp_ms);
      end
      w.duty = driven_duty;
      w.done = 1'b0;
      return w;
   endfunction

   // exact targets onto the outputs; ends the fade
   function automatic duty_write_type drive_ramp_end();
      duty_write_type w;
      driven_duty = ramp_to;
      ramping = 1'b0;
      w.duty = driven_duty;
      w.done = 1'b1;
      return w;
   endfunction

   // advance the fade for one request beat; returns 1 when a write follows
   function automatic bit advance_fade(input logic act, input duty_set_type tgt,
                                       input logic [SW-1:0] ms,
                                       output duty_write_type w);
      w = '0;
      if (act == ACT_SET) begin
         ramp_from  = driven_duty;
         ramp_to    = tgt;
         ramp_ms    = ms;
         ramp_steps = 12'(ms >> TICK_SHIFT);
         if (ramp_steps == 0) begin
            ramp_step = '0;
            w = drive_ramp_end();
            return 1'b1;
         end
         ramp_step = 12'd1;
         ramping = 1'b1;
         w = drive_ramp_step();
         return 1'b1;
      end
      // tick
      if (!ramping)
         return 1'b0;
      if (ramp_step < ramp_steps) begin
         ramp_step++;
         w = drive_ramp_step();
         return 1'b1;
      end
      w = drive_ramp_end();
      return 1'b1;
   endfunction

   // watch both channels at each edge; response first so a beat never meets its own request
   always @(posedge clock) begin : watch
      duty_write_type got;
      duty_write_type want;
      duty_write_type next_write;
      duty_set_type   req_targets;
      if (reset) begin
         driven_duty = '0;
         ramp_from   = '0;
         ramp_to     = '0;
         ramp_ms     = '0;
         ramp_step   = '0;
         ramp_steps  = '0;
         ramping     = 1'b0;
         duty_writes_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.duty = {rsp.duty_e, rsp.duty_d, rsp.duty_c, rsp.duty_b, rsp.duty_a};
            got.done = rsp.fade_done;
            if (duty_writes_due.size() == 0) begin
               mismatches++;
               $display("%0t: duty write with none due, expected none got %h done %b",
                        $time, got.duty, got.done);
            end else begin
               want = duty_writes_due.pop_front();
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  if (got.duty[ch] !== want.duty[ch]) begin
                     mismatches++;
                     $display("%0t: duty channel %0d expected %0d got %0d",
                              $time, ch, want.duty[ch], got.duty[ch]);
                  end
               end
               if (got.done !== want.done) begin
                  mismatches++;
                  $display("%0t: fade_done expected %b got %b", $time, want.done, got.done);
               end
            end
         end
         if (req.valid && req.ready) begin
            req_targets = {req.target_e, req.target_d, req.target_c, req.target_b,
                           req.target_a};
            if (advance_fade(req.action, req_targets, req.duration_ms, next_write))
               duty_writes_due.push_back(next_write);
         end
      end
      pending <= duty_writes_due.size();
   end

endmodule

// ===== bench/multi_channel_pwm_fader_tb.sv =====
// Testbench top for the PWM fader: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module multi_channel_pwm_fader_tb import mcpf_pkg::*;;

   localparam int DW = DEF_DUTY_BITS;
   localparam int SW = DEF_DURATION_BITS;
   localparam int BEAT_GOAL = 2000;

   typedef logic [CHANNELS-1:0][DW-1:0] duty_set_type;

   logic clock = 1'b0;
   logic reset;
   int   chk_errors;
   int   chk_pending;
   bit   req_no_gap = 1'b0;
   bit   rsp_no_stall = 1'b0;
   int   beats = 0;

   mcpf_req_if req_if ();
   mcpf_rsp_if rsp_if ();

   multi_channel_pwm_fader dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   fade_duty_checker chk (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .errors  (chk_errors),
      .pending (chk_pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // duty with a bias toward the extremes
   function automatic duty_set_type pick_duties();
      duty_set_type d;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         case ($urandom_range(0, 5))
            0:       d[ch] = '0;
            1:       d[ch] = '1;
            default: d[ch] = DW'($urandom_range(0, (1 << DW) - 1));
         endcase
      end
      return d;
   endfunction

   // one request beat after a random gap; returns at the accepting edge
   task automatic send_beat(input logic act, input duty_set_type tgt, input logic [SW-1:0] ms);
      int gap;
      if ($urandom_range(0, 40) == 0)
         req_no_gap = !req_no_gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.target_a    <= tgt[0];
      req_if.target_b    <= tgt[1];
      req_if.target_c    <= tgt[2];
      req_if.target_d    <= tgt[3];
      req_if.target_e    <= tgt[4];
      req_if.duration_ms <= ms;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_set(input duty_set_type tgt, input logic [SW-1:0] ms);
      send_beat(ACT_SET, tgt, ms);
   endtask

   // tick carries random payload that the block must ignore
   task automatic send_tick();
      send_beat(ACT_TICK, pick_duties(), SW'($urandom));
   endtask

   // response side: random stall per beat
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin : rsp_loop
         int stall;
         if ($urandom_range(0, 40) == 0)
            rsp_no_stall = !rsp_no_stall;
         stall = rsp_no_stall ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // reset, directed beats, random sequences, drain, verdict
   initial begin : stimulus
      logic [SW-1:0] ms;
      int            ticks;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_SET;
      req_if.target_a    <= '0;
      req_if.target_b    <= '0;
      req_if.target_c    <= '0;
      req_if.target_d    <= '0;
      req_if.target_e    <= '0;
      req_if.duration_ms <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tick with no fade running
      send_tick();
      // immediate sets at both ends of the short range
      send_set({CHANNELS{8'hff}}, 16'd0);
      send_set({8'h00, 8'hff, 8'h80, 8'h01, 8'hfe}, 16'd15);
      // one-step fade: step reaches the target yet is not the last write
      send_set({8'hfe, 8'h01, 8'h7f, 8'hff, 8'h00}, 16'd16);
      send_tick();
      send_tick();
      // three steps, mixed directions, truncation toward zero
      send_set({8'h00, 8'hff, 8'h80, 8'h03, 8'hff}, 16'd50);
      repeat (4) send_tick();
      // longest fade, cut short by a new set that restarts from driven duties
      send_set({8'hff, 8'h00, 8'hff, 8'h00, 8'h55}, 16'hffff);
      repeat (2) send_tick();
      send_set({8'h00, 8'hff, 8'h00, 8'hff, 8'haa}, 16'd17);
      repeat (3) send_tick();
      // set during a fade that lands on an immediate write
      send_set({8'h12, 8'h34, 8'h56, 8'h78, 8'h9a}, 16'd96);
      send_tick();
      send_set({8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 16'd8);
      send_tick();

      // random sequences: mostly complete fades, some cut short, some noise
      while (beats < BEAT_GOAL) begin
         case ($urandom_range(0, 9))
            0: send_tick();
            1: begin
               send_set(pick_duties(), SW'($urandom_range(0, 15)));
               beats++;
            end
            2, 3, 4, 5, 6, 7: begin
               ms = SW'($urandom_range(16, 400));
               send_set(pick_duties(), ms);
               ticks = (ms >> TICK_SHIFT) + 1;
               repeat (ticks) send_tick();
               beats += 1 + ticks;
               if ($urandom_range(0, 3) == 0)
                  send_tick();
            end
            default: begin
               ms = $urandom_range(0, 1) ? SW'($urandom) : SW'($urandom_range(16, 1023));
               send_set(pick_duties(), ms);
               ticks = $urandom_range(0, 6);
               repeat (ticks) send_tick();
               beats += 1 + ticks;
            end
         endcase
      end
      req_if.valid <= 1'b0;

      // drain, then allow for a last beat in flight
      while (chk_pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (chk_errors == 0 && chk_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
